FILE: hw/rtl/lpht_pkg.sv
// Shared types and constants for the linear probe hash table.
// Used by linear_probe_hash_table and its testbench.
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;
  localparam int unsigned MaxLogSize = 12;
  localparam int unsigned SlotCount  = 1 << MaxLogSize;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 13;
  localparam int unsigned EntryWidth = 1 + KeyWidth + ValueWidth;
  localparam logic [31:0] HashMult   = 32'd2654435769;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef logic [MaxLogSize-1:0] slot_t;

  typedef enum logic [1:0] {
    CmdFind    = 2'd0,
    CmdAdd     = 2'd1,
    CmdReplace = 2'd2,
    CmdDelete  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StExists   = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] entry_value;
    logic                  fail_if_absent;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  key_was_present;
    logic [ValueWidth-1:0] value_out;
    logic [CountWidth-1:0] entries_used;
  } out_word_t;

  // Home slot: top ld bits of the low 32 bits of the product.
  function automatic slot_t home_of(logic [31:0] prod, logic [3:0] ld);
    logic [31:0] sh;
    sh = prod >> (6'd32 - {2'b0, ld});
    return sh[MaxLogSize-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// Top level of the linear probe hash table.
// Depends on lpht_pkg and lpht_ram.
//
// Usage: words enter on in_valid_i/in_stall_o and results leave on
// out_valid_o/out_stall_i; one result word per input word. The table
// size register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, the block does not enforce this. Each slot
// is one RAM word {valid, key, value}; a single port is read and written,
// each slot read taking an address state, then a check state. Probes
// step from slot to slot; a delete then scans further slots to compact
// its run. After reset a clearing pass writes every slot empty, and no
// input word is taken during it. One word is worked on at a time.
// A finished result sits in the output register; the next word is
// accepted while it waits, but its result holds until the register
// drains, so a stalled receiver only delays the block.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [3:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lpht_pkg::in_word_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lpht_pkg::out_word_t       out_data_o
);
  import lpht_pkg::*;

  typedef enum logic [8:0] {
    SClear = 9'b000000001,
    SIdle  = 9'b000000010,
    SHash  = 9'b000000100,
    SPRd   = 9'b000001000,
    SPChk  = 9'b000010000,
    SDRd   = 9'b000100000,
    SDChk  = 9'b001000000,
    SDone  = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] size_q;
  logic [3:0] ld;
  in_word_t req_q;
  slot_t pos_q, pos_d, h_q, h_d, s_q, s_d;
  logic [MaxLogSize:0] cnt_q, cnt_d;
  logic [31:0] prod_q;
  logic [CountWidth-1:0] used_q, used_d;
  out_word_t res_q, res_d;
  out_word_t out_q;
  logic out_v_q;
  logic ram_we;
  slot_t ram_addr;
  logic [EntryWidth-1:0] ram_wdata, ram_rdata;
  logic r_valid;
  logic [KeyWidth-1:0] r_key;
  logic [ValueWidth-1:0] r_val;
  slot_t mask, rhome, run_dist;

  assign ld = (size_q < 4'd3) ? 4'd3 : ((size_q > 4'(MaxLogSize)) ? 4'(MaxLogSize) : size_q);
  assign mask = slot_t'(({{MaxLogSize{1'b0}}, 1'b1} << ld) - 1'b1);
  assign {r_valid, r_key, r_val} = ram_rdata;
  assign rhome = home_of(r_key * HashMult, ld);
  assign run_dist = (h_q - rhome) & mask;

  lpht_ram #(.Width(EntryWidth), .Depth(SlotCount)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q; pos_d = pos_q; h_d = h_q; s_d = s_q; cnt_d = cnt_q;
    used_d = used_q; res_d = res_q;
    ram_we = 1'b0; ram_addr = pos_q; ram_wdata = '0;
    case (state_q)
      SClear: begin
        ram_we = 1'b1; ram_addr = pos_q; pos_d = pos_q + 1'b1;
        if (pos_q == '1) state_d = SIdle;
      end
      SIdle: if (in_valid_i) state_d = SHash;
      SHash: begin
        pos_d = home_of(prod_q, ld); cnt_d = '0; state_d = SPRd;
      end
      SPRd: begin
        ram_addr = pos_q; state_d = SPChk;
      end
      SPChk: begin
        ram_addr = pos_q;
        res_d.value_out = '0;
        res_d.key_was_present = r_valid && (r_key == req_q.key);
        res_d.status = StOk;
        state_d = SDone;
        if (r_valid && r_key != req_q.key) begin
          if (cnt_q + 1'b1 == ({1'b0, mask} + 1'b1)) begin
            // Every slot visited, the table is full: StFull, or StNotFound for find/delete.
            case (req_q.cmd)
              CmdFind, CmdDelete: res_d.status = StNotFound;
              default: res_d.status = StFull;
            endcase
          end else begin
            cnt_d = cnt_q + 1'b1; pos_d = (pos_q - 1'b1) & mask; state_d = SPRd;
          end
        end else if (r_valid) begin
          case (req_q.cmd)
            CmdFind: res_d.value_out = r_val;
            CmdAdd: res_d.status = StExists;
            CmdReplace: begin
              res_d.value_out = r_val;
              ram_we = 1'b1; ram_wdata = {1'b1, req_q.key, req_q.entry_value};
            end
            default: begin
              h_d = pos_q; cnt_d = (MaxLogSize+1)'(1); s_d = (pos_q - 1'b1) & mask;
              state_d = SDRd;
            end
          endcase
        end else begin
          case (req_q.cmd)
            CmdFind, CmdDelete: res_d.status = StNotFound;
            CmdAdd: begin
              ram_we = 1'b1; ram_wdata = {1'b1, req_q.key, req_q.entry_value};
              if (used_q != CountMax) used_d = used_q + 1'b1;
            end
            default: begin
              if (req_q.fail_if_absent) res_d.status = StNotFound;
              else begin
                ram_we = 1'b1; ram_wdata = {1'b1, req_q.key, req_q.entry_value};
                if (used_q != CountMax) used_d = used_q + 1'b1;
              end
            end
          endcase
        end
      end
      SDRd: begin
        ram_addr = s_q;
        if (cnt_q == {1'b0, mask} + 1'b1) begin
          ram_addr = h_q; ram_we = 1'b1; ram_wdata = '0;
          if (used_q != '0) used_d = used_q - 1'b1;
          state_d = SDone;
        end else state_d = SDChk;
      end
      SDChk: begin
        if (!r_valid) begin
          ram_addr = h_q; ram_we = 1'b1; ram_wdata = '0;
          if (used_q != '0) used_d = used_q - 1'b1;
          state_d = SDone;
        end else if (run_dist == '0 || {1'b0, run_dist} > cnt_q) begin
          ram_addr = h_q; ram_we = 1'b1; ram_wdata = ram_rdata;
          h_d = s_q; s_d = (s_q - 1'b1) & mask; cnt_d = (MaxLogSize+1)'(1);
          state_d = SDRd;
        end else begin
          s_d = (s_q - 1'b1) & mask; cnt_d = cnt_q + 1'b1; state_d = SDRd;
        end
      end
      SDone: begin
        res_d.entries_used = used_q;
        if (!out_v_q || !out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; size_q <= 4'd12; pos_q <= '0; cnt_q <= '0;
      used_q <= '0; out_v_q <= 1'b0; h_q <= '0; s_q <= '0;
    end else begin
      state_q <= state_d; pos_q <= pos_d; cnt_q <= cnt_d; used_q <= used_d;
      h_q <= h_d; s_q <= s_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (state_q == SDone && (!out_v_q || !out_stall_i)) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
    end
  end

  // The working result is built in res_q; out_q only changes when it may.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == SDone && (!out_v_q || !out_stall_i)) out_q <= res_d;
    if (state_q == SIdle && in_valid_i) req_q <= in_data_i;
    if (state_q == SIdle) prod_q <= in_data_i.key * HashMult;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SClear |-> in_stall_o) else $error("input taken during clear");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPRd || state_q == SPChk || state_q == SDRd || state_q == SDChk)
    |-> cnt_q <= {1'b0, mask} + 1'b1) else $error("probe count overflow");
endmodule
`default_nettype wire

FILE: hw/rtl/lpht_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

FILE: tb/linear_probe_hash_table_tb.sv
// Self-checking testbench for the linear probe hash table.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  // Predicts each result word from its own copy of the table and checks
  // the result words as they arrive.
  class table_scoreboard;
    bit          slot_used [SlotCount];
    logic [31:0] slot_key  [SlotCount];
    logic [31:0] slot_val  [SlotCount];
    int unsigned count;
    logic [3:0]  size_reg;
    out_word_t   expected_q [$];
    int unsigned errors;

    function int unsigned log_size();
      if (size_reg < 3) return 3;
      if (size_reg > MaxLogSize) return MaxLogSize;
      return size_reg;
    endfunction

    function int unsigned home(logic [31:0] key, int unsigned ld);
      logic [31:0] prod;
      prod = key * HashMult;
      return prod >> (32 - ld);
    endfunction

    // Slot holding the key or the first empty slot of its run; -1 if full.
    function int find_slot(logic [31:0] key, int unsigned ld);
      int unsigned sz, h, s;
      sz = 1 << ld;
      h = home(key, ld);
      for (int unsigned i = 0; i < sz; i++) begin
        s = (h - i) & (sz - 1);
        if (!slot_used[s] || slot_key[s] == key) return s;
      end
      return -1;
    endfunction

    function int next_to_shift(int unsigned h, int unsigned ld);
      int unsigned sz, s, d;
      sz = 1 << ld;
      for (int unsigned i = 1; i < sz; i++) begin
        s = (h - i) & (sz - 1);
        if (!slot_used[s]) break;
        d = (h - home(slot_key[s], ld)) & (sz - 1);
        if (d < 1 || d > i) return s;
      end
      return -1;
    endfunction

    function void note_word(in_word_t w);
      int unsigned ld, h;
      int pos, s;
      bit present;
      out_word_t r;
      ld = log_size();
      pos = find_slot(w.key, ld);
      present = pos >= 0 && slot_used[pos];
      r = '0;
      r.status = StOk;
      r.key_was_present = present;
      case (cmd_e'(w.cmd))
        CmdFind: begin
          if (present) r.value_out = slot_val[pos];
          else r.status = StNotFound;
        end
        CmdAdd: begin
          if (pos < 0) r.status = StFull;
          else if (present) r.status = StExists;
          else begin
            slot_used[pos] = 1;
            slot_key[pos] = w.key;
            slot_val[pos] = w.entry_value;
            if (count < CountMax) count++;
          end
        end
        CmdReplace: begin
          if (pos < 0) r.status = StFull;
          else if (!present && w.fail_if_absent) r.status = StNotFound;
          else begin
            if (present) r.value_out = slot_val[pos];
            else if (count < CountMax) count++;
            slot_used[pos] = 1;
            slot_key[pos] = w.key;
            slot_val[pos] = w.entry_value;
          end
        end
        default: begin
          if (!present) r.status = StNotFound;
          else begin
            // Backward-shift: pull later run members into the gap.
            h = pos;
            s = next_to_shift(h, ld);
            while (s >= 0) begin
              slot_key[h] = slot_key[s];
              slot_val[h] = slot_val[s];
              h = s;
              s = next_to_shift(h, ld);
            end
            slot_used[h] = 0;
            if (count > 0) count--;
          end
        end
      endcase
      r.entries_used = CountWidth'(count);
      expected_q.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.key_was_present !== want.key_was_present) begin
        $error("key_was_present: expected %0d, got %0d",
               want.key_was_present, got.key_was_present);
        errors++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %h, got %h", want.value_out, got.value_out);
        errors++;
      end
      if (got.entries_used !== want.entries_used) begin
        $error("entries_used: expected %0d, got %0d",
               want.entries_used, got.entries_used);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      cfg_we_i = 0;
  logic [3:0] cfg_wdata_i = '0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_word_t out_data_o;

  table_scoreboard sb = new();
  bit quiet = 0;
  logic [31:0] key_pool [$];

  linear_probe_hash_table DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Result side: check accepted words, stall in random bursts.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_word(out_data_o);
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_stall_i <= stall_left > 0 && !quiet;
  end

  task automatic send_word(cmd_e cmd, logic [31:0] key, logic [31:0] val, bit fia);
    in_word_t w;
    w.cmd = cmd;
    w.key = key;
    w.entry_value = val;
    w.fail_if_absent = fia;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  // Drain, let the block settle, then write the size register.
  task automatic set_size(logic [3:0] sz);
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.size_reg = sz;
    key_pool.delete();
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (key_pool.size() < 2 || $urandom_range(0, 9) == 0) begin
      k = $urandom();
      if (key_pool.size() < 40) key_pool.push_back(k);
      return k;
    end
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic random_words(int unsigned n);
    repeat (n) send_word(cmd_e'($urandom_range(0, 3)), pick_key(), $urandom(),
                         $urandom_range(0, 1));
  endtask

  initial begin
    sb.size_reg = 12;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: an 8-slot table driven to full, then partly emptied again.
    set_size(3);
    send_word(CmdFind, 32'h0, 32'h0, 0);
    send_word(CmdDelete, 32'hffff_ffff, 32'h0, 0);
    send_word(CmdReplace, 32'h1234_5678, 32'hffff_ffff, 1);
    send_word(CmdReplace, 32'h1234_5678, 32'hffff_ffff, 0);
    send_word(CmdReplace, 32'h1234_5678, 32'h0, 1);
    send_word(CmdAdd, 32'h0, 32'h0, 0);
    send_word(CmdAdd, 32'h0, 32'h5555_aaaa, 0);
    send_word(CmdAdd, 32'hffff_ffff, 32'haaaa_5555, 1);
    send_word(CmdFind, 32'hffff_ffff, 32'h0, 0);
    for (int i = 1; i <= 6; i++) send_word(CmdAdd, 32'(i * 8), $urandom(), 0);
    send_word(CmdAdd, 32'h9999, 32'h1, 0);
    send_word(CmdReplace, 32'h9999, 32'h1, 0);
    send_word(CmdDelete, 32'h9999, 32'h0, 0);
    send_word(CmdFind, 32'h9999, 32'h0, 0);
    send_word(CmdReplace, 32'h8, 32'h7, 1);
    for (int i = 1; i <= 6; i++) send_word(CmdDelete, 32'(i * 8), 32'h0, 0);
    send_word(CmdDelete, 32'h0, 32'h0, 0);

    random_words(100);
    set_size(12);
    random_words(130);
    set_size(0);    // clamps to the smallest table
    random_words(100);
    set_size(15);   // clamps to the largest table
    random_words(100);
    set_size(5);
    random_words(100);
    set_size(8);
    quiet = 1;
    random_words(100);

    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
